>>> src/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on the rising clock, off while reset is held.
`define QAU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Concurrent assertion that is checked during reset as well.
`define QAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> src/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Widths, opcodes, status codes and the sequencer state type of the unit.
// ----------------------------------------------------------------------------
package qau_pkg;
    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int MAX_EXPONENT_DEF    = 15;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_NEG   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_SADD  = 4'd4;
    localparam logic [3:0] OP_SSUB  = 4'd5;
    localparam logic [3:0] OP_SMUL  = 4'd6;
    localparam logic [3:0] OP_SDIV  = 4'd7;
    localparam logic [3:0] OP_CONJ  = 4'd8;
    localparam logic [3:0] OP_NORM  = 4'd9;
    localparam logic [3:0] OP_RECIP = 4'd10;
    localparam logic [3:0] OP_DIV   = 4'd11;
    localparam logic [3:0] OP_POW   = 4'd12;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SUMSQ = 7'b0000010,
        S_SQRT  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_HAM   = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } qau_state_t;

    // Request to the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic en;
        logic sub;
        logic rnd;
    } qau_mac_ctl_t;
endpackage

>>> src/qau_mac.sv
// ----------------------------------------------------------------------------
// qau_mac
// Shared signed multiplier feeding a wide registered accumulator.
// ----------------------------------------------------------------------------
module qau_mac import qau_pkg::*; #(
    parameter int CW = COMPONENT_WIDTH_DEF,
    parameter int FB = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic signed [CW-1:0] op_x,
    input  logic signed [CW-1:0] op_y,
    input  qau_mac_ctl_t         ctl,
    output logic signed [2*CW+3:0] acc
);
    localparam int AW = 2*CW+4;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FB-1);
    logic signed [2*CW-1:0] prod;
    logic signed [AW-1:0]   term;
    logic signed [AW-1:0]   acc_reg;

    assign prod = op_x * op_y;

    // Rounded terms add one half LSB, then shift arithmetically.
    always_comb begin
        if (ctl.rnd) begin
            term = (AW'(prod) + HALF) >>> FB;
        end else begin
            term = AW'(prod);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (ctl.en) begin
            acc_reg <= ctl.sub ? acc_reg - term : acc_reg + term;
        end
    end

    assign acc = acc_reg;
endmodule

>>> src/qau_divsqrt.sv
// ----------------------------------------------------------------------------
// qau_divsqrt
// Bit-serial unsigned divider and integer square root, one bit per cycle.
// ----------------------------------------------------------------------------
module qau_divsqrt import qau_pkg::*; #(
    parameter int NW = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start_div,
    input  logic          start_sqrt,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] result
);
    localparam int CNTW = $clog2(NW+1);
    logic [NW-1:0]   q_reg;
    logic [NW:0]     rem_reg;
    logic [NW-1:0]   n_reg;
    logic [NW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            sqrt_reg;
    logic            busy_reg;
    logic [NW:0]     rem_sh;
    logic [NW:0]     trial;

    // Division: shift in one numerator bit. Square root: shift in two bits
    // and try root*4+1 against the partial remainder.
    always_comb begin
        if (sqrt_reg) begin
            rem_sh = {rem_reg[NW-2:0], n_reg[NW-1:NW-2]};
            trial  = {q_reg[NW-2:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[NW-1:0], n_reg[NW-1]};
            trial  = {1'b0, d_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start_div || start_sqrt) begin
            busy_reg <= 1'b1;
            sqrt_reg <= start_sqrt;
            n_reg    <= num;
            d_reg    <= den;
            q_reg    <= '0;
            rem_reg  <= '0;
            cnt_reg  <= start_sqrt ? CNTW'(NW/2) : CNTW'(NW);
        end else if (busy_reg) begin
            n_reg <= sqrt_reg ? {n_reg[NW-3:0], 2'b00} : {n_reg[NW-2:0], 1'b0};
            if (rem_sh >= trial) begin
                rem_reg <= rem_sh - trial;
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign result = q_reg;
endmodule

>>> src/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Quaternion ALU on signed fixed-point components with saturation.
// ----------------------------------------------------------------------------
// Usage: a request on the s_ channel carries an opcode, quaternions a and b
// and an exponent; the unit returns exactly one result request on the m_
// channel with four components and a status code.
// The unit handles one request at a time: s_axis_tready is high only while
// the sequencer is idle and no result is waiting.
// Element-wise and scalar add/sub/neg/conj are combinational on the held
// operands. Products go one component at a time through the single shared
// multiplier (Hamilton product or scalar multiply). Norm sums four squares
// and takes the integer square root on the bit-serial unit. Scalar divide,
// reciprocal and quaternion divide make one pass of the bit-serial divider per
// component. Power runs one Hamilton product per exponent step.
// The rate is set by the shared multiplier and the serial divider.
// Reset (synchronous, active low aresetn) returns the sequencer to idle and
// drops any pending result. A stalled receiver simply holds the result in
// the output register; no new request is taken until it is delivered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module quaternion_arithmetic_unit import qau_pkg::*; #(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
    parameter int MAX_EXPONENT    = MAX_EXPONENT_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata, low bit up: a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, exponent(4)
    input  logic [8*COMPONENT_WIDTH+7:0] s_axis_tdata,
    // tuser: opcode (4 bits)
    input  logic [3:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata, low bit up: r_w, r_x, r_y, r_z
    output logic [4*COMPONENT_WIDTH-1:0] m_axis_tdata,
    // tuser: status (2 bits)
    output logic [1:0] m_axis_tuser
);
    localparam int CW = COMPONENT_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int AW = 2*CW+4;
    localparam int NW = 2*CW;
    localparam int EW = 4;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = CW'(1) <<< FB;
    localparam logic [EW-1:0] EMAX =
        (MAX_EXPONENT > 15) ? EW'(15) : EW'(MAX_EXPONENT);

    qau_state_t state_reg;
    logic [3:0]           op_reg;
    logic signed [CW-1:0] a_reg [4];
    logic signed [CW-1:0] b_reg [4];
    logic signed [CW-1:0] r_reg [4];
    logic signed [CW-1:0] t_reg [4];
    logic [EW-1:0]        e_reg;
    logic [1:0]           comp_reg;
    logic [2:0]           step_reg;
    logic                 sat_reg;
    logic                 dz_reg;
    logic                 divwait_reg;
    logic                 recip_phase_reg;
    logic [NW-1:0]        den_reg;
    logic [CW-1:0]        out_reg [4];
    logic [1:0]           out_st_reg;
    logic                 out_valid_reg;

    logic signed [CW-1:0] mx, my;
    qau_mac_ctl_t         mctl;
    logic signed [AW-1:0] acc;
    logic                 ds_div, ds_sqrt, ds_busy;
    logic [NW-1:0]        ds_num, ds_res;
    logic signed [CW-1:0] acc_sat;
    logic                 acc_ovf;

    qau_mac #(.CW(CW), .FB(FB)) u_mac (
        .aclk(aclk), .op_x(mx), .op_y(my), .ctl(mctl), .acc(acc)
    );

    qau_divsqrt #(.NW(NW)) u_ds (
        .aclk(aclk), .aresetn(aresetn), .start_div(ds_div), .start_sqrt(ds_sqrt),
        .num(ds_num), .den(den_reg), .busy(ds_busy), .result(ds_res)
    );

    function automatic logic signed [CW-1:0] sat_w(input logic signed [AW-1:0] v);
        if (v > AW'(CMAX)) begin
            return CMAX;
        end else if (v < AW'(CMIN)) begin
            return CMIN;
        end
        return v[CW-1:0];
    endfunction

    assign acc_sat = sat_w(acc);
    assign acc_ovf = (acc > AW'(CMAX)) || (acc < AW'(CMIN));

    // Hamilton term table: for output component c and slot k, the a index,
    // the b index and the sign of the term.
    function automatic logic [4:0] ham_sel(input logic [1:0] c, input logic [1:0] k);
        logic [1:0] bi;
        logic       neg;
        bi  = c ^ k;
        neg = 1'b0;
        unique case ({c, k}) inside
            4'b0001, 4'b0010, 4'b0011: neg = 1'b1;
            4'b0111: neg = 1'b1;
            4'b1001: neg = 1'b1;
            4'b1110: neg = 1'b1;
            default: neg = 1'b0;
        endcase
        return {neg, k, bi};
    endfunction

    // Left operand of the product: running result for power, else a.
    logic signed [CW-1:0] hl [4];
    logic signed [CW-1:0] hr [4];
    logic [4:0]           hs;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            hl[i] = (op_reg == OP_POW) ? r_reg[i] : a_reg[i];
            hr[i] = (op_reg == OP_POW) ? a_reg[i] :
                    (op_reg == OP_DIV) ? t_reg[i] : b_reg[i];
        end
        hs = ham_sel(comp_reg, step_reg[1:0]);
    end

    // Reciprocal source quaternion and magnitude of the current component.
    // For the norm, the held sum of squares is the root operand.
    logic signed [CW-1:0] rq;
    logic [CW-1:0]        rq_mag;
    logic [NW-1:0]        quo_clip;
    logic signed [NW:0]   quo_s;
    logic                 rneg;
    always_comb begin
        rq     = (op_reg == OP_RECIP) ? a_reg[comp_reg] : b_reg[comp_reg];
        rq_mag = rq[CW-1] ? CW'(-rq) : CW'(rq);
        if (op_reg == OP_SDIV) begin
            ds_num = NW'({a_reg[comp_reg][CW-1] ? CW'(-a_reg[comp_reg])
                                                : CW'(a_reg[comp_reg])}) << FB;
            rneg   = a_reg[comp_reg][CW-1] ^ b_reg[0][CW-1];
        end else if (op_reg == OP_NORM) begin
            ds_num = den_reg;
            rneg   = 1'b0;
        end else begin
            ds_num = NW'(rq_mag) << (2*FB);
            rneg   = rq[CW-1] ^ (comp_reg != 2'd0);
        end
        quo_clip = ds_res;
        quo_s    = rneg ? -$signed({1'b0, quo_clip}) : $signed({1'b0, quo_clip});
    end

    logic signed [CW-1:0] quo_sat;
    logic                 quo_ovf;
    assign quo_ovf = (quo_s > (NW+1)'(CMAX)) || (quo_s < (NW+1)'(CMIN));
    assign quo_sat = (quo_s > (NW+1)'(CMAX)) ? CMAX :
                     (quo_s < (NW+1)'(CMIN)) ? CMIN : quo_s[CW-1:0];

    // Sum of squares from the accumulator, clamped to the unsigned range.
    logic [NW-1:0] sumsq;
    assign sumsq = (acc[AW-1:NW] != '0) ? {NW{1'b1}} : acc[NW-1:0];

    // Simple element-wise work, done combinationally.
    logic signed [CW:0] ew [4];
    logic signed [CW-1:0] ew_r [4];
    logic [3:0] ew_ovf;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            unique case (op_reg)
                OP_ADD:  ew[i] = (CW+1)'(a_reg[i]) + (CW+1)'(b_reg[i]);
                OP_SUB:  ew[i] = (CW+1)'(a_reg[i]) - (CW+1)'(b_reg[i]);
                OP_NEG:  ew[i] = -(CW+1)'(a_reg[i]);
                OP_SADD: ew[i] = (i == 0) ? (CW+1)'(a_reg[0]) + (CW+1)'(b_reg[0])
                                          : (CW+1)'(a_reg[i]);
                OP_SSUB: ew[i] = (i == 0) ? (CW+1)'(a_reg[0]) - (CW+1)'(b_reg[0])
                                          : (CW+1)'(a_reg[i]);
                OP_CONJ: ew[i] = (i == 0) ? (CW+1)'(a_reg[0]) : -(CW+1)'(a_reg[i]);
                default: ew[i] = '0;
            endcase
            ew_ovf[i] = (ew[i] > (CW+1)'(CMAX)) || (ew[i] < (CW+1)'(CMIN));
            ew_r[i]   = (ew[i] > (CW+1)'(CMAX)) ? CMAX :
                        (ew[i] < (CW+1)'(CMIN)) ? CMIN : ew[i][CW-1:0];
        end
    end

    logic s_acc;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // Multiplier operand selection and accumulator control.
    always_comb begin
        mx   = '0;
        my   = '0;
        mctl = '{clear: 1'b0, en: 1'b0, sub: 1'b0, rnd: 1'b0};
        unique case (state_reg)
            S_SUMSQ: begin
                mx = (op_reg == OP_NORM || op_reg == OP_RECIP)
                     ? a_reg[step_reg[1:0]] : b_reg[step_reg[1:0]];
                my = mx;
                mctl.en = !step_reg[2];
            end
            S_HAM: begin
                if (op_reg == OP_SMUL) begin
                    mx = a_reg[comp_reg];
                    my = b_reg[0];
                    mctl.en = (step_reg == 3'd0);
                end else begin
                    mx = hl[hs[3:2]];
                    my = hr[hs[1:0]];
                    mctl.en = !step_reg[2];
                end
                mctl.sub = hs[4] && (op_reg != OP_SMUL);
                mctl.rnd = 1'b1;
                mctl.clear = (step_reg == 3'd7);
            end
            default: mctl.clear = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            divwait_reg   <= 1'b0;
            ds_div        <= 1'b0;
            ds_sqrt       <= 1'b0;
        end else begin
            ds_div  <= 1'b0;
            ds_sqrt <= 1'b0;
            if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        op_reg <= s_axis_tuser;
                        for (int i = 0; i < 4; i++) begin
                            a_reg[i] <= s_axis_tdata[i*CW +: CW];
                            b_reg[i] <= s_axis_tdata[(4+i)*CW +: CW];
                            r_reg[i] <= '0;
                        end
                        e_reg    <= (s_axis_tdata[8*CW +: EW] > EMAX) ? EMAX
                                    : s_axis_tdata[8*CW +: EW];
                        sat_reg  <= 1'b0;
                        dz_reg   <= 1'b0;
                        comp_reg <= '0;
                        step_reg <= '0;
                        recip_phase_reg <= 1'b0;
                        divwait_reg <= 1'b0;
                        unique case (s_axis_tuser) inside
                            OP_MUL, OP_SMUL: state_reg <= S_HAM;
                            OP_NORM, OP_RECIP, OP_DIV: state_reg <= S_SUMSQ;
                            OP_SDIV: begin
                                den_reg   <= NW'(s_axis_tdata[4*CW+CW-1] ?
                                    CW'(-$signed(s_axis_tdata[4*CW +: CW]))
                                    : s_axis_tdata[4*CW +: CW]);
                                state_reg <= S_DIV;
                            end
                            OP_POW: state_reg <= S_DONE;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SUMSQ: begin
                    // Four squares, then a wait step while the last square lands in the accumulator.
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd4) begin
                        step_reg <= '0;
                        if (op_reg == OP_NORM) begin
                            ds_sqrt   <= 1'b1;
                            den_reg   <= sumsq;
                            state_reg <= S_SQRT;
                        end else if (sumsq == '0) begin
                            dz_reg    <= 1'b1;
                            state_reg <= S_DONE;
                        end else begin
                            den_reg   <= sumsq;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_SQRT: begin
                    if (!ds_sqrt && !ds_busy) begin
                        if (ds_res > NW'(CMAX)) begin
                            r_reg[0] <= CMAX;
                            sat_reg  <= 1'b1;
                        end else begin
                            r_reg[0] <= ds_res[CW-1:0];
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (op_reg == OP_SDIV && den_reg == '0) begin
                        dz_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (!divwait_reg) begin
                        ds_div      <= 1'b1;
                        divwait_reg <= 1'b1;
                    end else if (!ds_div && !ds_busy) begin
                        divwait_reg <= 1'b0;
                        sat_reg     <= sat_reg | quo_ovf;
                        if (op_reg == OP_DIV) begin
                            t_reg[comp_reg] <= quo_sat;
                        end else begin
                            r_reg[comp_reg] <= quo_sat;
                        end
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd3) begin
                            state_reg <= (op_reg == OP_DIV) ? S_HAM : S_DONE;
                        end
                    end
                end
                S_HAM: begin
                    // Four product slots (only the first for a scalar multiply), a step to
                    // take the last sum, then a clear step before the next component. The
                    // quaternion divide keeps its reciprocal in t_reg, so its products
                    // go straight to the result.
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd4) begin
                        if (op_reg == OP_DIV) begin
                            r_reg[comp_reg] <= acc_sat;
                        end else begin
                            t_reg[comp_reg] <= acc_sat;
                        end
                        sat_reg  <= sat_reg | acc_ovf;
                        step_reg <= 3'd7;
                    end
                    if (step_reg == 3'd7) begin
                        step_reg <= '0;
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd3) begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (op_reg == OP_MUL || op_reg == OP_SMUL) begin
                        r_reg <= t_reg;
                    end
                    if (op_reg == OP_POW) begin
                        if (!recip_phase_reg) begin
                            r_reg[0] <= ONE;
                            recip_phase_reg <= 1'b1;
                        end else if (e_reg != '0) begin
                            e_reg     <= e_reg - 1'b1;
                            state_reg <= S_HAM;
                            op_reg    <= OP_POW;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        state_reg <= S_OUT;
                    end
                    if (op_reg == OP_POW && recip_phase_reg && comp_reg == 2'd0 &&
                        step_reg == 3'd0 && e_reg != '0) begin
                        r_reg <= r_reg;
                    end
                end
                S_OUT: begin
                    for (int i = 0; i < 4; i++) begin
                        if (dz_reg) begin
                            out_reg[i] <= '0;
                        end else if (op_reg == OP_ADD || op_reg == OP_SUB ||
                                     op_reg == OP_NEG || op_reg == OP_SADD ||
                                     op_reg == OP_SSUB || op_reg == OP_CONJ) begin
                            out_reg[i] <= ew_r[i];
                        end else begin
                            out_reg[i] <= r_reg[i];
                        end
                    end
                    if (dz_reg) begin
                        out_st_reg <= ST_DZ;
                    end else if (sat_reg || ((op_reg == OP_ADD || op_reg == OP_SUB ||
                             op_reg == OP_NEG || op_reg == OP_SADD ||
                             op_reg == OP_SSUB || op_reg == OP_CONJ) && (ew_ovf != '0))) begin
                        out_st_reg <= ST_SAT;
                    end else begin
                        out_st_reg <= ST_OK;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            // Power: after each product, the new value becomes the running result.
            if (state_reg == S_HAM && op_reg == OP_POW && step_reg == 3'd7 &&
                comp_reg == 2'd3) begin
                r_reg[0] <= t_reg[0];
                r_reg[1] <= t_reg[1];
                r_reg[2] <= t_reg[2];
                r_reg[3] <= t_reg[3];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign m_axis_tuser  = out_st_reg;

    `QAU_ASSERT(a_no_take_busy, aclk, aresetn,
        (state_reg != S_IDLE) |-> !s_axis_tready, "request taken while busy")
    `QAU_ASSERT(a_out_hold, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
    `QAU_ASSERT(a_dz_zero, aclk, aresetn,
        (m_axis_tvalid && m_axis_tuser == ST_DZ) |-> (m_axis_tdata == '0),
        "divide by zero with nonzero data")
endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion arithmetic unit. A short table of
// directed requests covers the operand extremes, every opcode and the
// saturation and divide-by-zero cases. Random requests follow. Each accepted
// request is predicted by a fixed-point quaternion evaluator in this file or
// typed in; each m_ channel result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import qau_pkg::*;

    // Opcodes with no operation behind them; the unit answers them with zero.
    localparam logic [3:0] OP_SPARE_LO  = 4'd13;
    localparam logic [3:0] OP_SPARE_MID = 4'd14;
    localparam logic [3:0] OP_SPARE_HI  = 4'd15;

    localparam logic [31:0] VMAX = 32'h7fff_ffff;
    localparam logic [31:0] VMIN = 32'h8000_0000;
    localparam logic [31:0] VONE = 32'h0001_0000;
    localparam longint      CMAX = 64'sd2147483647;
    localparam longint      CMIN = -64'sd2147483648;
    localparam int          RANDOM_REQUESTS = 1930;

    // One request: opcode, quaternions a and b (index 0 is w), exponent.
    typedef struct packed {
        logic [3:0]       op;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [3:0]       ex;
    } quat_req_t;

    // One result: components r (index 0 is w) and the status code.
    typedef struct packed {
        logic [3:0][31:0] r;
        logic [1:0]       st;
    } quat_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [263:0] s_axis_tdata = '0;
    logic [3:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    quat_res_t pending_results[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Directed table: request, whether the result is typed in, and that result.
    quat_req_t dir_req[$];
    bit        dir_fixed[$];
    quat_res_t dir_res[$];

    quaternion_arithmetic_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Fixed-point quaternion evaluator.
    // ------------------------------------------------------------------------
    function automatic longint clamp(longint v, inout bit hit);
        if (v > CMAX) begin
            hit = 1'b1;
            return CMAX;
        end
        if (v < CMIN) begin
            hit = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    // Exact product, rounded half up to the fraction width.
    function automatic longint fx_mul(longint x, longint y);
        return (x * y + 64'sd32768) >>> 16;
    endfunction

    function automatic void hamilton(input longint p[4], input longint q[4],
                                     output longint o[4], inout bit hit);
        longint w, x, y, z;
        w = fx_mul(p[0], q[0]) - fx_mul(p[1], q[1]) - fx_mul(p[2], q[2])
            - fx_mul(p[3], q[3]);
        x = fx_mul(p[0], q[1]) + fx_mul(p[1], q[0]) + fx_mul(p[2], q[3])
            - fx_mul(p[3], q[2]);
        y = fx_mul(p[0], q[2]) - fx_mul(p[1], q[3]) + fx_mul(p[2], q[0])
            + fx_mul(p[3], q[1]);
        z = fx_mul(p[0], q[3]) + fx_mul(p[1], q[2]) - fx_mul(p[2], q[1])
            + fx_mul(p[3], q[0]);
        o[0] = clamp(w, hit);
        o[1] = clamp(x, hit);
        o[2] = clamp(y, hit);
        o[3] = clamp(z, hit);
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Sum of squares, pinned to all ones when it overflows 64 bits.
    function automatic longint unsigned square_sum(longint v[4]);
        longint unsigned s, m, q;
        s = 0;
        for (int n = 0; n < 4; n++) begin
            m = magnitude(v[n]);
            q = m * m;
            if (s + q < s) return 64'hffff_ffff_ffff_ffff;
            s += q;
        end
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Conjugate over squared magnitude; returns 0 for a zero quaternion.
    function automatic bit reciprocal(input longint q[4], output longint o[4],
                                      inout bit hit);
        longint unsigned den, quo;
        bit neg;
        den = square_sum(q);
        if (den == 0) return 1'b0;
        for (int n = 0; n < 4; n++) begin
            quo = (magnitude(q[n]) << 32) / den;
            neg = (q[n] < 0) != (n != 0);
            if (quo > (64'd1 << 62)) quo = 64'd1 << 62;
            o[n] = clamp(neg ? -longint'(quo) : longint'(quo), hit);
        end
        return 1'b1;
    endfunction

    function automatic quat_res_t quat_eval(quat_req_t q);
        longint a[4], b[4], r[4], t[4];
        longint unsigned root;
        bit hit, dz;
        quat_res_t res;
        hit = 1'b0;
        dz = 1'b0;
        for (int n = 0; n < 4; n++) begin
            a[n] = longint'($signed(q.a[n]));
            b[n] = longint'($signed(q.b[n]));
            r[n] = 0;
        end
        case (q.op)
            OP_ADD: for (int n = 0; n < 4; n++) r[n] = clamp(a[n] + b[n], hit);
            OP_SUB: for (int n = 0; n < 4; n++) r[n] = clamp(a[n] - b[n], hit);
            OP_NEG: for (int n = 0; n < 4; n++) r[n] = clamp(-a[n], hit);
            OP_MUL: hamilton(a, b, r, hit);
            OP_SADD, OP_SSUB: begin
                r = a;
                r[0] = clamp(q.op == OP_SADD ? a[0] + b[0] : a[0] - b[0], hit);
            end
            OP_SMUL: for (int n = 0; n < 4; n++) r[n] = clamp(fx_mul(a[n], b[0]), hit);
            OP_SDIV: begin
                if (b[0] == 0) dz = 1'b1;
                else for (int n = 0; n < 4; n++) r[n] = clamp((a[n] <<< 16) / b[0], hit);
            end
            OP_CONJ: begin
                r[0] = a[0];
                for (int n = 1; n < 4; n++) r[n] = clamp(-a[n], hit);
            end
            OP_NORM: begin
                root = int_sqrt(square_sum(a));
                if (root > longint'(CMAX)) begin
                    hit = 1'b1;
                    r[0] = CMAX;
                end else begin
                    r[0] = longint'(root);
                end
            end
            OP_RECIP: if (!reciprocal(a, r, hit)) dz = 1'b1;
            OP_DIV: begin
                if (!reciprocal(b, t, hit)) dz = 1'b1;
                else hamilton(a, t, r, hit);
            end
            OP_POW: begin
                r[0] = 64'sd65536;
                for (int k = 0; k < q.ex; k++) begin
                    hamilton(r, a, t, hit);
                    r = t;
                end
            end
            default: ;
        endcase
        for (int n = 0; n < 4; n++) res.r[n] = dz ? 32'd0 : r[n][31:0];
        res.st = dz ? ST_DZ : (hit ? ST_SAT : ST_OK);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic quat_req_t make_req(logic [3:0] op,
                                           logic [31:0] aw, logic [31:0] ax,
                                           logic [31:0] ay, logic [31:0] az,
                                           logic [31:0] bw, logic [31:0] bx,
                                           logic [31:0] by, logic [31:0] bz,
                                           logic [3:0] ex);
        quat_req_t q;
        q.op = op;
        q.a = {az, ay, ax, aw};
        q.b = {bz, by, bx, bw};
        q.ex = ex;
        return q;
    endfunction

    function automatic quat_res_t make_res(logic [31:0] v, logic [1:0] st);
        quat_res_t res;
        res.r = {v, v, v, v};
        res.st = st;
        return res;
    endfunction

    // Component values weighted toward zero, the limits and small numbers,
    // so that products and quotients stay mostly inside the range.
    function automatic logic [31:0] rand_component();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return VMAX;
            2: return VMIN;
            3, 4: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
            5: return $urandom_range(0, 1) ? VONE : -VONE;
            6: return $urandom_range(0, 32'h800) - 32'h400;
            default: return $urandom;
        endcase
    endfunction

    function automatic quat_req_t rand_req();
        quat_req_t q;
        q.op = $urandom_range(0, 19) == 0 ? $urandom_range(13, 15) : $urandom_range(0, 12);
        for (int n = 0; n < 4; n++) begin
            q.a[n] = rand_component();
            q.b[n] = rand_component();
        end
        q.ex = $urandom_range(0, 15);
        // Occasionally a zero divisor, and sometimes a complex right operand.
        if ($urandom_range(0, 9) == 0) begin
            q.b = '0;
            if (q.op == OP_RECIP) q.a = '0;
        end else if ($urandom_range(0, 7) == 0) begin
            q.b[2] = '0;
            q.b[3] = '0;
        end
        return q;
    endfunction

    task automatic add_row(quat_req_t q, bit fixed, quat_res_t res);
        dir_req.push_back(q);
        dir_fixed.push_back(fixed);
        dir_res.push_back(res);
    endtask

    // Presents one request, with random idle cycles first, and records its
    // expected result once the handshake completes.
    task automatic send_request(quat_req_t q, quat_res_t expected);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'd0, q.ex, q.b, q.a};
        s_axis_tuser = q.op;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(expected);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver backpressure, changed at the falling edge.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker.
    always @(posedge aclk) begin
        quat_res_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.r = m_axis_tdata;
            got.st = m_axis_tuser;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected r=%h st=%0d, got r=%h st=%0d",
                                 want.r, want.st, got.r, got.st);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        quat_req_t q;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_row(make_req(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, ST_OK));
        add_row(make_req(OP_ADD, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 0),
                1, make_res(VMAX, ST_SAT));
        add_row(make_req(OP_SUB, VMIN, VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, VMAX, 0),
                1, make_res(VMIN, ST_SAT));
        add_row(make_req(OP_NEG, VMIN, VMIN, VMIN, VMIN, 0, 0, 0, 0, 0),
                1, make_res(VMAX, ST_SAT));
        add_row(make_req(OP_NEG, VMAX, 5, -7, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_MUL, VONE, 2 * VONE, -3 * VONE, 4 * VONE,
                         VONE, -VONE, VONE, 3, 0), 0, '0);
        add_row(make_req(OP_MUL, VMAX, VMIN, VMAX, VMIN, VMIN, VMIN, VMAX, VMAX, 15),
                0, '0);
        add_row(make_req(OP_SADD, VMAX, 1, 2, 3, 1, 9, 9, 9, 0), 0, '0);
        add_row(make_req(OP_SSUB, VMIN, 1, 2, 3, 1, 9, 9, 9, 0), 0, '0);
        add_row(make_req(OP_SMUL, VONE, -VONE, VMAX, VMIN, 2 * VONE, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_SDIV, VONE, 2, 3, 4, 0, 5, 6, 7, 0), 1, make_res(0, ST_DZ));
        add_row(make_req(OP_SDIV, VMAX, -VONE, 7, VMIN, 3, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_CONJ, VMIN, VMIN, 1, -1, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_NORM, 3 * VONE, 4 * VONE, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_NORM, VMIN, VMIN, VMIN, VMIN, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_RECIP, 0, 0, 0, 0, 1, 1, 1, 1, 0), 1, make_res(0, ST_DZ));
        add_row(make_req(OP_RECIP, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_RECIP, VONE, -VONE, VONE, VONE, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(OP_DIV, VONE, 2, 3, 4, 0, 0, 0, 0, 0), 1, make_res(0, ST_DZ));
        add_row(make_req(OP_DIV, VONE, VONE, 0, 0, 2 * VONE, VONE, 0, 0, 0), 0, '0);
        add_row(make_req(OP_POW, VMAX, VMIN, 5, 6, 0, 0, 0, 0, 0), 0,
                '{r: {32'd0, 32'd0, 32'd0, VONE}, st: ST_OK});
        add_row(make_req(OP_POW, VONE, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 15), 0, '0);
        add_row(make_req(OP_POW, 2 * VONE, VONE, VONE, VONE, 0, 0, 0, 0, 15), 0, '0);
        add_row(make_req(OP_SPARE_LO, VMAX, 1, 2, 3, 4, 5, 6, 7, 4'hf), 1, make_res(0, ST_OK));
        add_row(make_req(OP_SPARE_MID, VMIN, 1, 2, 3, 4, 5, 6, 7, 0), 1, make_res(0, ST_OK));
        add_row(make_req(OP_SPARE_HI, 1, 1, 1, 1, 1, 1, 1, 1, 1), 1, make_res(0, ST_OK));
        // The power row with exponent zero has its result typed in as one.
        dir_fixed[20] = 1'b1;

        for (int i = 0; i < dir_req.size(); i++)
            send_request(dir_req[i], dir_fixed[i] ? dir_res[i] : quat_eval(dir_req[i]));
        drain_results();

        // Three phases of flow control; between them the sender waits for
        // every outstanding result.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 19 : (phase == 1 ? 87 : 0);
            recv_idle_pct = phase == 0 ? 87 : (phase == 1 ? 19 : 0);
            for (int i = 0; i < RANDOM_REQUESTS / 3; i++) begin
                q = rand_req();
                send_request(q, quat_eval(q));
            end
            drain_results();
        end

        repeat (500) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end
endmodule
